// ----- rtl/gar_pkg.sv -----
`default_nettype none

package gar_pkg;

  // Geometry of the row table
  localparam int ROWS      = 64;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CNT_W     = $clog2(ROWS + 1);
  localparam int MAX_WIDTH = 4096;

  // Reset values of the configuration registers
  localparam logic [6:0]  RST_MAX_ROWS      = 7'd64;
  localparam logic [12:0] RST_MAX_ROW_WIDTH = 13'd2048;
  localparam logic [5:0]  RST_ALIGN_MASK    = 6'd7;

  // Smallest class height and glyph count ceiling
  localparam logic [7:0] MIN_HEIGHT = 8'd8;
  localparam logic [9:0] COUNT_MAX  = 10'd1023;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_ROWS      = 2'd0;
  localparam logic [1:0] CFG_MAX_ROW_WIDTH = 2'd1;
  localparam logic [1:0] CFG_ALIGN_MASK    = 2'd2;

  // Request codes
  localparam logic [1:0] OP_PLACE   = 2'd0;
  localparam logic [1:0] OP_TOUCH   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_BAD_ROW  = 2'd2;

  // One row record as held in the row memory
  typedef struct packed {
    logic [7:0]  height;
    logic [3:0]  format;
    logic [12:0] fill;
    logic [31:0] stamp;
    logic [31:0] birth;
    logic [9:0]  count;
  } row_rec_t;

  // One result item
  typedef struct packed {
    logic [1:0]       status;
    logic [ROW_W-1:0] row_index;
    logic [12:0]      start_x;
    logic [12:0]      row_span;
    logic             row_created;
    logic             evicted;
    logic [ROW_W-1:0] evicted_row;
    logic             row_freed;
  } result_t;

  // Row width for a class height under the current width clamp
  function automatic logic [12:0] width_for(input logic [7:0] h, input logic [12:0] mrw);
    logic [12:0] lim;
    logic [13:0] w;
    lim = (mrw > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : mrw;
    w   = {1'b0, h, 5'b0};
    if (w > {1'b0, lim}) begin
      w = {1'b0, lim};
    end
    if (w < {6'b0, h}) begin
      w = {6'b0, h};
    end
    w = (w + 14'd7) & ~14'd7;
    return w[12:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gar_ram.sv -----
`default_nettype none

module gar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/glyph_atlas_row_allocator.sv -----
`default_nettype none

// Channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------------
// in       | in_valid / in_stall     | op, glyph/font sizes, format_class, row_select
// out      | out_valid / out_stall   | status, row_index, start_x, row_span, flags
// cfg      | cfg_we                  | cfg_index, cfg_wdata
//
// A place request scans the row memory once for fit and, when no row fits and the
// row limit is reached, once more for the least recently used row: one row a cycle
// through the single read port. Touch and release pass through S_ROW_UPD;
// rejected requests go straight to S_DONE.
// rst_n is synchronous; it clears all row valid bits and counters, no sweep.
// in_stall is high while an item is at work or its result waits for out.

module glyph_atlas_row_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_glyph_width,
  input  wire logic [7:0]  in_glyph_height,
  input  wire logic [7:0]  in_font_height,
  input  wire logic [3:0]  in_format_class,
  input  wire logic [5:0]  in_row_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [5:0]       out_row_index,
  output logic [12:0]      out_start_x,
  output logic [12:0]      out_row_span,
  output logic             out_row_created,
  output logic             out_evicted,
  output logic [5:0]       out_evicted_row,
  output logic             out_row_freed,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_FIT     = 7'b0000010,
    S_LRU     = 7'b0000100,
    S_NEW     = 7'b0001000,
    S_COMMIT  = 7'b0010000,
    S_ROW_UPD = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  localparam int RW = gar_pkg::ROW_W;
  localparam int CW = gar_pkg::CNT_W;

  // Sequencer and global state
  state_t                  state_r, state_nxt;
  logic [gar_pkg::ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [CW-1:0]           rows_in_use_r, rows_in_use_nxt;
  logic [31:0]             use_cnt_r, use_cnt_nxt;
  logic [31:0]             birth_cnt_r, birth_cnt_nxt;

  // Configuration
  logic [6:0]  max_rows_r, max_rows_nxt;
  logic [12:0] max_row_width_r, max_row_width_nxt;
  logic [5:0]  align_mask_r, align_mask_nxt;

  // Latched request
  logic [1:0]  op_r, op_nxt;
  logic [7:0]  gw_r, gw_nxt;
  logic [3:0]  fc_r, fc_nxt;
  logic [RW-1:0] rs_r, rs_nxt;
  logic [7:0]  h_r, h_nxt;
  logic [12:0] w_r, w_nxt;

  // Scan pointer and read pipeline
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic          pend_r, pend_nxt;
  logic [RW-1:0] pend_idx_r, pend_idx_nxt;

  // Scan trackers
  logic                fresh_hit_r, fresh_hit_nxt;
  logic                fresh_fit_r, fresh_fit_nxt;
  logic [RW-1:0]       fresh_idx_r, fresh_idx_nxt;
  gar_pkg::row_rec_t   fresh_rec_r, fresh_rec_nxt;
  logic                best_hit_r, best_hit_nxt;
  logic [RW-1:0]       best_idx_r, best_idx_nxt;
  gar_pkg::row_rec_t   best_rec_r, best_rec_nxt;
  logic                free_hit_r, free_hit_nxt;
  logic [RW-1:0]       free_idx_r, free_idx_nxt;
  logic                lru_hit_r, lru_hit_nxt;
  logic [RW-1:0]       lru_idx_r, lru_idx_nxt;
  logic [31:0]         lru_stamp_r, lru_stamp_nxt;
  logic                ev_r, ev_nxt;
  logic [RW-1:0]       evr_r, evr_nxt;

  // Selected row for an update
  logic [RW-1:0]       sel_idx_r, sel_idx_nxt;
  gar_pkg::row_rec_t   sel_rec_r, sel_rec_nxt;

  // Result staging and output register
  gar_pkg::result_t res_r, res_nxt;
  gar_pkg::result_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Row memory ports
  logic              ram_we;
  logic [RW-1:0]     ram_wr_addr;
  gar_pkg::row_rec_t ram_wr_rec;
  logic [RW-1:0]     ram_rd_addr;
  logic [$bits(gar_pkg::row_rec_t)-1:0] ram_rd_data;
  gar_pkg::row_rec_t rd_rec;

  // Working values
  logic        in_acc;
  logic [7:0]  in_h;
  logic        issue;
  logic        scan_done;
  logic        cur_valid;
  logic        cur_match;
  logic        cur_fits;
  logic [6:0]  limit;
  logic [8:0]  inc;
  logic [RW-1:0] new_slot;
  logic        new_ok;
  logic        rs_ok;
  logic [12:0] rd_span;

  gar_ram #(
    .WIDTH($bits(gar_pkg::row_rec_t)),
    .DEPTH(gar_pkg::ROWS)
  ) u_row_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_rec),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_rec = gar_pkg::row_rec_t'(ram_rd_data);

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);

  // Class height of the incoming request
  always_comb begin
    in_h = (in_glyph_width > in_glyph_height) ? in_glyph_width : in_glyph_height;
    if (in_font_height > in_h) begin
      in_h = in_font_height;
    end
    if (in_h < gar_pkg::MIN_HEIGHT) begin
      in_h = gar_pkg::MIN_HEIGHT;
    end
  end

  // Scan step: one row issued, the previous row's data compared
  assign issue     = (scan_idx_r < CW'(gar_pkg::ROWS));
  assign scan_done = !issue && !pend_r;
  assign cur_valid = row_valid_r[pend_idx_r];
  assign cur_match = cur_valid && (rd_rec.height == h_r) && (rd_rec.format == fc_r);
  assign cur_fits  = (({1'b0, rd_rec.fill} + 14'(gw_r)) <= {1'b0, w_r});

  assign ram_rd_addr = (state_r == S_IDLE) ? in_row_select[RW-1:0] : scan_idx_r[RW-1:0];

  // Effective row limit, clamped to 1..ROWS
  always_comb begin
    if (max_rows_r == 7'd0) begin
      limit = 7'd1;
    end else if (max_rows_r > 7'(gar_pkg::ROWS)) begin
      limit = 7'(gar_pkg::ROWS);
    end else begin
      limit = max_rows_r;
    end
  end

  // Aligned fill increment
  assign inc = ({1'b0, gw_r} + {3'b0, align_mask_r}) & ~{3'b0, align_mask_r};

  // Lowest free slot after a possible eviction
  assign new_ok   = ev_r || free_hit_r;
  assign new_slot = (ev_r && (!free_hit_r || evr_r < free_idx_r)) ? evr_r : free_idx_r;

  assign rs_ok   = ({1'b0, in_row_select} < 7'(gar_pkg::ROWS))
                   && row_valid_r[in_row_select[RW-1:0]];
  assign rd_span = gar_pkg::width_for(rd_rec.height, max_row_width_r);

  always_comb begin
    state_nxt         = state_r;
    row_valid_nxt     = row_valid_r;
    rows_in_use_nxt   = rows_in_use_r;
    use_cnt_nxt       = use_cnt_r;
    birth_cnt_nxt     = birth_cnt_r;
    max_rows_nxt      = max_rows_r;
    max_row_width_nxt = max_row_width_r;
    align_mask_nxt    = align_mask_r;
    op_nxt            = op_r;
    gw_nxt            = gw_r;
    fc_nxt            = fc_r;
    rs_nxt            = rs_r;
    h_nxt             = h_r;
    w_nxt             = w_r;
    scan_idx_nxt      = scan_idx_r;
    pend_nxt          = 1'b0;
    pend_idx_nxt      = scan_idx_r[RW-1:0];
    fresh_hit_nxt     = fresh_hit_r;
    fresh_fit_nxt     = fresh_fit_r;
    fresh_idx_nxt     = fresh_idx_r;
    fresh_rec_nxt     = fresh_rec_r;
    best_hit_nxt      = best_hit_r;
    best_idx_nxt      = best_idx_r;
    best_rec_nxt      = best_rec_r;
    free_hit_nxt      = free_hit_r;
    free_idx_nxt      = free_idx_r;
    lru_hit_nxt       = lru_hit_r;
    lru_idx_nxt       = lru_idx_r;
    lru_stamp_nxt     = lru_stamp_r;
    ev_nxt            = ev_r;
    evr_nxt           = evr_r;
    sel_idx_nxt       = sel_idx_r;
    sel_rec_nxt       = sel_rec_r;
    res_nxt           = res_r;
    out_nxt           = out_r;
    out_valid_nxt     = out_valid_r;
    ram_we            = 1'b0;
    ram_wr_addr       = sel_idx_r;
    ram_wr_rec        = sel_rec_r;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        gar_pkg::CFG_MAX_ROWS:      max_rows_nxt      = cfg_wdata[6:0];
        gar_pkg::CFG_MAX_ROW_WIDTH: max_row_width_nxt = cfg_wdata;
        gar_pkg::CFG_ALIGN_MASK:    align_mask_nxt    = cfg_wdata[5:0];
        default: ;
      endcase
    end

    // Drain the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = in_op;
          gw_nxt       = in_glyph_width;
          fc_nxt       = in_format_class;
          rs_nxt       = in_row_select[RW-1:0];
          h_nxt        = in_h;
          w_nxt        = gar_pkg::width_for(in_h, max_row_width_r);
          scan_idx_nxt = '0;
          fresh_hit_nxt = 1'b0;
          fresh_fit_nxt = 1'b0;
          best_hit_nxt  = 1'b0;
          free_hit_nxt  = 1'b0;
          lru_hit_nxt   = 1'b0;
          ev_nxt        = 1'b0;
          evr_nxt       = '0;
          res_nxt       = '0;
          case (in_op) inside
            gar_pkg::OP_PLACE: begin
              if (in_glyph_width == 8'd0 || in_glyph_height == 8'd0) begin
                res_nxt.status = gar_pkg::ST_ZERO;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FIT;
              end
            end
            gar_pkg::OP_TOUCH, gar_pkg::OP_RELEASE: begin
              res_nxt.row_index = in_row_select;
              if (rs_ok) begin
                state_nxt = S_ROW_UPD;
              end else begin
                res_nxt.status = gar_pkg::ST_BAD_ROW;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              res_nxt.status = gar_pkg::ST_BAD_ROW;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_FIT: begin
        // Advance the scan pointer
        pend_nxt = issue;
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // Track lowest free slot, freshest row and best fitting row
        if (pend_r) begin
          if (!cur_valid && !free_hit_r) begin
            free_hit_nxt = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
          if (cur_match && (!fresh_hit_r || rd_rec.birth > fresh_rec_r.birth)) begin
            fresh_hit_nxt = 1'b1;
            fresh_fit_nxt = cur_fits;
            fresh_idx_nxt = pend_idx_r;
            fresh_rec_nxt = rd_rec;
          end
          if (cur_match && cur_fits &&
              (!best_hit_r || rd_rec.fill > best_rec_r.fill ||
               (rd_rec.fill == best_rec_r.fill && rd_rec.birth > best_rec_r.birth))) begin
            best_hit_nxt = 1'b1;
            best_idx_nxt = pend_idx_r;
            best_rec_nxt = rd_rec;
          end
        end
        // Choose the row once all rows are seen
        if (scan_done) begin
          if (fresh_hit_r && fresh_fit_r) begin
            sel_idx_nxt = fresh_idx_r;
            sel_rec_nxt = fresh_rec_r;
            state_nxt   = S_COMMIT;
          end else if (best_hit_r) begin
            sel_idx_nxt = best_idx_r;
            sel_rec_nxt = best_rec_r;
            state_nxt   = S_COMMIT;
          end else if (rows_in_use_r >= CW'(limit)) begin
            scan_idx_nxt = '0;
            state_nxt    = S_LRU;
          end else begin
            state_nxt = S_NEW;
          end
        end
      end

      S_LRU: begin
        pend_nxt = issue;
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        // Keep the smallest stamp, lowest index on ties
        if (pend_r && cur_valid && (!lru_hit_r || rd_rec.stamp < lru_stamp_r)) begin
          lru_hit_nxt   = 1'b1;
          lru_idx_nxt   = pend_idx_r;
          lru_stamp_nxt = rd_rec.stamp;
        end
        // Evict the victim
        if (scan_done) begin
          if (lru_hit_r) begin
            row_valid_nxt[lru_idx_r] = 1'b0;
            if (rows_in_use_r != '0) begin
              rows_in_use_nxt = rows_in_use_r - 1'b1;
            end
            ev_nxt  = 1'b1;
            evr_nxt = lru_idx_r;
          end
          state_nxt = S_NEW;
        end
      end

      S_NEW: begin
        res_nxt.evicted     = ev_r;
        res_nxt.evicted_row = evr_r;
        if (new_ok) begin
          ram_we            = 1'b1;
          ram_wr_addr       = new_slot;
          ram_wr_rec.height = h_r;
          ram_wr_rec.format = fc_r;
          ram_wr_rec.fill   = 13'(inc);
          ram_wr_rec.stamp  = use_cnt_r;
          ram_wr_rec.birth  = birth_cnt_r;
          ram_wr_rec.count  = 10'd1;
          row_valid_nxt[new_slot] = 1'b1;
          rows_in_use_nxt   = rows_in_use_nxt + 1'b1;
          birth_cnt_nxt     = birth_cnt_r + 1'b1;
          use_cnt_nxt       = use_cnt_r + 1'b1;
          res_nxt.status      = gar_pkg::ST_OK;
          res_nxt.row_index   = new_slot;
          res_nxt.row_span    = w_r;
          res_nxt.row_created = 1'b1;
        end else begin
          res_nxt.status = gar_pkg::ST_BAD_ROW;
        end
        state_nxt = S_DONE;
      end

      S_COMMIT: begin
        // Append the glyph to the chosen row
        ram_we           = 1'b1;
        ram_wr_addr      = sel_idx_r;
        ram_wr_rec       = sel_rec_r;
        ram_wr_rec.fill  = sel_rec_r.fill + 13'(inc);
        ram_wr_rec.stamp = use_cnt_r;
        if (sel_rec_r.count < gar_pkg::COUNT_MAX) begin
          ram_wr_rec.count = sel_rec_r.count + 1'b1;
        end
        use_cnt_nxt       = use_cnt_r + 1'b1;
        res_nxt.status    = gar_pkg::ST_OK;
        res_nxt.row_index = sel_idx_r;
        res_nxt.start_x   = sel_rec_r.fill;
        res_nxt.row_span  = w_r;
        state_nxt         = S_DONE;
      end

      S_ROW_UPD: begin
        ram_wr_addr      = rs_r;
        ram_wr_rec       = rd_rec;
        res_nxt.status   = gar_pkg::ST_OK;
        res_nxt.row_span = rd_span;
        if (op_r == gar_pkg::OP_TOUCH) begin
          ram_we           = 1'b1;
          ram_wr_rec.stamp = use_cnt_r;
          use_cnt_nxt      = use_cnt_r + 1'b1;
        end else if (rd_rec.count <= 10'd1) begin
          // Drop the emptied row
          row_valid_nxt[rs_r] = 1'b0;
          if (rows_in_use_r != '0) begin
            rows_in_use_nxt = rows_in_use_r - 1'b1;
          end
          res_nxt.row_freed = 1'b1;
        end else begin
          ram_we           = 1'b1;
          ram_wr_rec.count = rd_rec.count - 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hand the item to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      row_valid_r     <= '0;
      rows_in_use_r   <= '0;
      use_cnt_r       <= '0;
      birth_cnt_r     <= '0;
      max_rows_r      <= gar_pkg::RST_MAX_ROWS;
      max_row_width_r <= gar_pkg::RST_MAX_ROW_WIDTH;
      align_mask_r    <= gar_pkg::RST_ALIGN_MASK;
      out_valid_r     <= 1'b0;
      pend_r          <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      row_valid_r     <= row_valid_nxt;
      rows_in_use_r   <= rows_in_use_nxt;
      use_cnt_r       <= use_cnt_nxt;
      birth_cnt_r     <= birth_cnt_nxt;
      max_rows_r      <= max_rows_nxt;
      max_row_width_r <= max_row_width_nxt;
      align_mask_r    <= align_mask_nxt;
      out_valid_r     <= out_valid_nxt;
      pend_r          <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    gw_r        <= gw_nxt;
    fc_r        <= fc_nxt;
    rs_r        <= rs_nxt;
    h_r         <= h_nxt;
    w_r         <= w_nxt;
    scan_idx_r  <= scan_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    fresh_hit_r <= fresh_hit_nxt;
    fresh_fit_r <= fresh_fit_nxt;
    fresh_idx_r <= fresh_idx_nxt;
    fresh_rec_r <= fresh_rec_nxt;
    best_hit_r  <= best_hit_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rec_r  <= best_rec_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    lru_hit_r   <= lru_hit_nxt;
    lru_idx_r   <= lru_idx_nxt;
    lru_stamp_r <= lru_stamp_nxt;
    ev_r        <= ev_nxt;
    evr_r       <= evr_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_rec_r   <= sel_rec_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_row_index   = out_r.row_index;
  assign out_start_x     = out_r.start_x;
  assign out_row_span    = out_r.row_span;
  assign out_row_created = out_r.row_created;
  assign out_evicted     = out_r.evicted;
  assign out_evicted_row = out_r.evicted_row;
  assign out_row_freed   = out_r.row_freed;

endmodule

`default_nettype wire

// ----- sim/glyph_atlas_row_allocator_tb.sv -----
`default_nettype none

module glyph_atlas_row_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic [7:0] font_height;
    logic [3:0] format_class;
    logic [5:0] row_select;
  } request_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op           = '0;
  logic [7:0]  in_glyph_width  = '0;
  logic [7:0]  in_glyph_height = '0;
  logic [7:0]  in_font_height  = '0;
  logic [3:0]  in_format_class = '0;
  logic [5:0]  in_row_select   = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_status;
  logic [5:0]  out_row_index;
  logic [12:0] out_start_x;
  logic [12:0] out_row_span;
  logic        out_row_created;
  logic        out_evicted;
  logic [5:0]  out_evicted_row;
  logic        out_row_freed;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_index       = '0;
  logic [12:0] cfg_wdata       = '0;

  glyph_atlas_row_allocator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_glyph_width  (in_glyph_width),
    .in_glyph_height (in_glyph_height),
    .in_font_height  (in_font_height),
    .in_format_class (in_format_class),
    .in_row_select   (in_row_select),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_row_index   (out_row_index),
    .out_start_x     (out_start_x),
    .out_row_span    (out_row_span),
    .out_row_created (out_row_created),
    .out_evicted     (out_evicted),
    .out_evicted_row (out_evicted_row),
    .out_row_freed   (out_row_freed),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Shadow of the configuration registers
  int unsigned cfg_rows_limit  = 64;
  int unsigned cfg_width_clamp = 2048;
  int unsigned cfg_align       = 7;

  // Shadow of the row table and counters
  bit          row_live    [gar_pkg::ROWS];
  int unsigned row_h       [gar_pkg::ROWS];
  int unsigned row_fmt     [gar_pkg::ROWS];
  int unsigned row_fill    [gar_pkg::ROWS];
  int unsigned row_used_at [gar_pkg::ROWS];
  int unsigned row_birth   [gar_pkg::ROWS];
  int unsigned row_cnt     [gar_pkg::ROWS];
  int unsigned live_rows;
  int unsigned use_count;
  int unsigned birth_count;

  gar_pkg::result_t expected_results [$];
  gar_pkg::result_t last_prediction;
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned tx_idle_pct = 30;
  int unsigned rx_idle_pct = 30;
  int unsigned rx_hold_req;
  int unsigned rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("glyph_atlas_row_allocator_tb: errors");
    $finish;
  end

  // Row width for a class height under the current clamp
  function automatic int unsigned span_for(int unsigned h);
    int unsigned lim;
    int unsigned w;
    lim = (cfg_width_clamp > gar_pkg::MAX_WIDTH) ? gar_pkg::MAX_WIDTH : cfg_width_clamp;
    w = h * 32;
    if (w > lim) w = lim;
    if (w < h) w = h;
    return (w + 7) & ~32'd7;
  endfunction

  // Advance the shadow table by one request and return the result it causes
  function automatic gar_pkg::result_t predict_result(request_t r);
    gar_pkg::result_t res;
    int unsigned h;
    int unsigned w;
    int unsigned lim;
    int unsigned sx;
    int          fresh;
    int          best;
    int          sel;
    int          lru;
    res = '0;
    case (r.op) inside
      gar_pkg::OP_PLACE: begin
        if (r.glyph_width == 0 || r.glyph_height == 0) begin
          res.status = gar_pkg::ST_ZERO;
          return res;
        end
        h = (r.glyph_width > r.glyph_height) ? r.glyph_width : r.glyph_height;
        if (r.font_height > h) h = r.font_height;
        if (h < gar_pkg::MIN_HEIGHT) h = gar_pkg::MIN_HEIGHT;
        w = span_for(h);
        fresh = -1;
        best  = -1;
        sel   = -1;
        // find the freshest row of the class and the fullest one that fits
        for (int i = 0; i < gar_pkg::ROWS; i++) begin
          if (row_live[i] && row_h[i] == h && row_fmt[i] == r.format_class) begin
            if (fresh < 0 || row_birth[i] > row_birth[fresh]) fresh = i;
            if (row_fill[i] + r.glyph_width <= w) begin
              if (best < 0 || row_fill[i] > row_fill[best] ||
                  (row_fill[i] == row_fill[best] && row_birth[i] > row_birth[best]))
                best = i;
            end
          end
        end
        if (fresh >= 0 && row_fill[fresh] + r.glyph_width <= w) sel = fresh;
        else sel = best;
        // open a new row, dropping the least recently used one at the limit
        if (sel < 0) begin
          lim = cfg_rows_limit;
          if (lim < 1) lim = 1;
          if (lim > gar_pkg::ROWS) lim = gar_pkg::ROWS;
          if (live_rows >= lim) begin
            lru = -1;
            for (int i = 0; i < gar_pkg::ROWS; i++) begin
              if (row_live[i] && (lru < 0 || row_used_at[i] < row_used_at[lru])) lru = i;
            end
            if (lru >= 0) begin
              row_live[lru] = 1'b0;
              if (live_rows > 0) live_rows--;
              res.evicted     = 1'b1;
              res.evicted_row = 6'(lru);
            end
          end
          for (int i = 0; i < gar_pkg::ROWS; i++) begin
            if (sel < 0 && !row_live[i]) sel = i;
          end
          if (sel < 0) begin
            res.status = gar_pkg::ST_BAD_ROW;
            return res;
          end
          row_live[sel]  = 1'b1;
          row_h[sel]     = h;
          row_fmt[sel]   = r.format_class;
          row_fill[sel]  = 0;
          row_cnt[sel]   = 0;
          row_birth[sel] = birth_count;
          birth_count++;
          live_rows++;
          res.row_created = 1'b1;
        end
        sx = row_fill[sel];
        row_fill[sel] = sx + ((r.glyph_width + cfg_align) & ~cfg_align);
        if (row_cnt[sel] < gar_pkg::COUNT_MAX) row_cnt[sel]++;
        row_used_at[sel] = use_count;
        use_count++;
        res.status    = gar_pkg::ST_OK;
        res.row_index = 6'(sel);
        res.start_x   = 13'(sx);
        res.row_span  = 13'(w);
      end
      gar_pkg::OP_TOUCH, gar_pkg::OP_RELEASE: begin
        res.row_index = r.row_select;
        if (!row_live[r.row_select]) begin
          res.status = gar_pkg::ST_BAD_ROW;
          return res;
        end
        res.status   = gar_pkg::ST_OK;
        res.row_span = 13'(span_for(row_h[r.row_select]));
        if (r.op == gar_pkg::OP_TOUCH) begin
          row_used_at[r.row_select] = use_count;
          use_count++;
        end else if (row_cnt[r.row_select] <= 1) begin
          row_cnt[r.row_select]  = 0;
          row_live[r.row_select] = 1'b0;
          if (live_rows > 0) live_rows--;
          res.row_freed = 1'b1;
        end else begin
          row_cnt[r.row_select]--;
        end
      end
      default: begin
        res.status = gar_pkg::ST_BAD_ROW;
      end
    endcase
    return res;
  endfunction

  function automatic request_t make_request(logic [1:0] op, int unsigned gw, int unsigned gh,
                                            int unsigned fh, int unsigned fc, int unsigned rs);
    request_t r;
    r.op           = op;
    r.glyph_width  = 8'(gw);
    r.glyph_height = 8'(gh);
    r.font_height  = 8'(fh);
    r.format_class = 4'(fc);
    r.row_select   = 6'(rs);
    return r;
  endfunction

  // Mostly well-formed places into a few classes, touches and releases of live rows
  function automatic request_t random_request();
    request_t    r;
    int          live_q [$];
    int unsigned roll;
    int unsigned h;
    int unsigned heights [6] = '{8, 12, 20, 40, 100, 255};
    r = make_request(2'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                     $urandom_range(255), $urandom_range(15), $urandom_range(63));
    roll = $urandom_range(99);
    if (roll < 55) begin
      h = heights[$urandom_range(5)];
      r.op           = gar_pkg::OP_PLACE;
      r.font_height  = 8'(h);
      r.glyph_width  = 8'($urandom_range(h, 1));
      r.glyph_height = 8'($urandom_range(h, 1));
      if ($urandom_range(4) != 0) r.format_class = 4'($urandom_range(1));
    end else if (roll < 65) begin
      r.op = gar_pkg::OP_PLACE;
    end else if (roll < 95) begin
      r.op = (roll < 80) ? gar_pkg::OP_TOUCH : gar_pkg::OP_RELEASE;
      for (int i = 0; i < gar_pkg::ROWS; i++) begin
        if (row_live[i]) live_q.push_back(i);
      end
      if (live_q.size() > 0 && $urandom_range(9) < 8)
        r.row_select = 6'(live_q[$urandom_range(live_q.size() - 1)]);
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_request(request_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= r.op;
    in_glyph_width  <= r.glyph_width;
    in_glyph_height <= r.glyph_height;
    in_font_height  <= r.font_height;
    in_format_class <= r.format_class;
    in_row_select   <= r.row_select;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_prediction = predict_result(r);
    expected_results.push_back(last_prediction);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_settings(int unsigned rows, int unsigned width, int unsigned align);
    cfg_we    <= 1'b1;
    cfg_index <= gar_pkg::CFG_MAX_ROWS;
    cfg_wdata <= 13'(rows);
    @(posedge clk);
    cfg_index <= gar_pkg::CFG_MAX_ROW_WIDTH;
    cfg_wdata <= 13'(width);
    @(posedge clk);
    cfg_index <= gar_pkg::CFG_ALIGN_MASK;
    cfg_wdata <= 13'(align);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_rows_limit  = rows & 127;
    cfg_width_clamp = width & 8191;
    cfg_align       = align & 63;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
  endtask

  task automatic compare_field(string what, int unsigned got, int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Receiver: random stalls, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_left != 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    gar_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 1, 0);
      end else begin
        want = expected_results.pop_front();
        compare_field("status", out_status, want.status);
        compare_field("row_index", out_row_index, want.row_index);
        compare_field("start_x", out_start_x, want.start_x);
        compare_field("row_span", out_row_span, want.row_span);
        compare_field("row_created", out_row_created, want.row_created);
        compare_field("evicted", out_evicted, want.evicted);
        compare_field("evicted_row", out_evicted_row, want.evicted_row);
        compare_field("row_freed", out_row_freed, want.row_freed);
      end
    end
  end

  // Zero sizes, bad rows, unknown op, field extremes, frees and slot reuse
  task automatic test_special_cases();
    send_request(make_request(gar_pkg::OP_PLACE, 0, 5, 9, 0, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 5, 0, 0, 3, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 0, 0, 255, 15, 63));
    send_request(make_request(OP_UNUSED, 255, 255, 255, 15, 63));
    send_request(make_request(gar_pkg::OP_TOUCH, 1, 1, 1, 0, 0));
    send_request(make_request(gar_pkg::OP_RELEASE, 0, 0, 0, 0, 63));
    send_request(make_request(gar_pkg::OP_PLACE, 1, 1, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 3, 2, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 255, 255, 255, 15, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 7, 8, 200, 15, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 8, 8, 0, 1, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 4, 9, 2, 0, 0));
    send_request(make_request(gar_pkg::OP_TOUCH, 0, 0, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_RELEASE, 0, 0, 0, 0, 2));
    send_request(make_request(gar_pkg::OP_PLACE, 6, 6, 100, 5, 0));
    send_request(make_request(gar_pkg::OP_RELEASE, 0, 0, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_RELEASE, 0, 0, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_TOUCH, 0, 0, 0, 0, 0));
    send_request(make_request(gar_pkg::OP_RELEASE, 0, 0, 0, 0, 1));
    send_request(make_request(gar_pkg::OP_TOUCH, 0, 0, 0, 0, 3));
  endtask

  // Narrow rows: fresh row first, then an older row that still fits
  task automatic test_fit_order();
    wait_drain();
    write_settings(64, 16, 0);
    send_request(make_request(gar_pkg::OP_PLACE, 8, 1, 12, 2, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 12, 1, 12, 2, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 6, 1, 12, 2, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 2, 1, 12, 2, 0));
    send_request(make_request(gar_pkg::OP_PLACE, 1, 1, 12, 2, 0));
  endtask

  // Fill one row with a run of glyphs back to back, then release it down to free
  task automatic test_release_to_free();
    int unsigned target;
    int unsigned guard;
    wait_drain();
    write_settings(64, 4096, 0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_request(make_request(gar_pkg::OP_PLACE, 1, 1, 128, 9, 0));
    target = last_prediction.row_index;
    repeat (24)
      send_request(make_request(gar_pkg::OP_PLACE, 1, 1, 128, 9, $urandom_range(63)));
    guard = 0;
    while (row_live[target] && guard < 40) begin
      send_request(make_request(gar_pkg::OP_RELEASE, $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom_range(15), target));
      guard++;
    end
    tx_idle_pct = 30;
    rx_idle_pct = 30;
  endtask

  // Random traffic under several settings, the extremes among them
  task automatic test_config_sweep();
    int unsigned rows_set  [6] = '{1, 64, 0, 127, 4, 33};
    int unsigned width_set [6] = '{8, 4096, 8191, 300, 1024, 2048};
    int unsigned align_set [6] = '{0, 63, 5, 1, 7, 31};
    for (int k = 0; k < 6; k++) begin
      wait_drain();
      write_settings(rows_set[k], width_set[k], align_set[k]);
      repeat (50) send_request(random_request());
    end
  endtask

  // Hold the receiver so the block backs up, then pause until it drains
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_hold_req = 400;
    repeat (10) send_request(random_request());
    tx_idle_pct = 30;
    wait_drain();
    repeat (10) send_request(random_request());
  endtask

  task automatic test_random_traffic();
    wait_drain();
    write_settings(64, 2048, 7);
    repeat (220) send_request(random_request());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_fit_order();
    test_release_to_free();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (200) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never returned", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("glyph_atlas_row_allocator_tb: clean");
    end else begin
      $display("glyph_atlas_row_allocator_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
